>>> rtl/rar_pkg.sv
// Shared types and constants for the rational arithmetic reduce unit.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package rar_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int NUMER_W           = 33;
  localparam int DENOM_W           = 31;

  // Operation codes carried on s_tuser.
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  // Multiplier operand selection.
  localparam logic [1:0] MUL_T1  = 2'd0;
  localparam logic [1:0] MUL_T2  = 2'd1;
  localparam logic [1:0] MUL_DEN = 2'd2;

  // Kind of result written to the output register.
  localparam logic [1:0] KIND_ERR  = 2'd0;
  localparam logic [1:0] KIND_ZERO = 2'd1;
  localparam logic [1:0] KIND_DIV  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       comb;
    logic       strip;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       res_wr;
    logic [1:0] res_kind;
  } cmd_t;

  typedef struct packed {
    logic in_err;
    logic u_zero;
    logic both_even;
    logic gcd_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/rar_ctrl.sv
// Sequencing state machine for the rational arithmetic reduce unit.
// Depends on rar_pkg for the command and status structs.
`default_nettype none

module rar_ctrl #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire rar_pkg::status_t status,
  output rar_pkg::cmd_t         cmd
);
  import rar_pkg::*;

  localparam int NW = 2 * OPERAND_WIDTH;
  localparam int CW = $clog2(NW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MA    = 4'd1;
  localparam logic [3:0] S_MB    = 4'd2;
  localparam logic [3:0] S_MD    = 4'd3;
  localparam logic [3:0] S_COMB  = 4'd4;
  localparam logic [3:0] S_STRIP = 4'd5;
  localparam logic [3:0] S_GCD   = 4'd6;
  localparam logic [3:0] S_DIVI  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]    state, state_next;
  logic [1:0]    kind, kind_next;
  logic [CW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= KIND_ERR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.res_kind = kind;
    state_next   = state;
    kind_next    = kind;
    cnt_next     = cnt;
    s_tready     = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (status.in_err) begin
            kind_next  = KIND_ERR;
            state_next = S_OUT;
          end else begin
            state_next = S_MA;
          end
        end
      end
      S_MA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_T1;
        state_next  = S_MB;
      end
      S_MB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_T2;
        state_next  = S_MD;
      end
      S_MD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DEN;
        state_next  = S_COMB;
      end
      S_COMB: begin
        cmd.comb   = 1'b1;
        state_next = S_STRIP;
      end
      S_STRIP: begin
        if (status.u_zero) begin
          kind_next  = KIND_ZERO;
          state_next = S_OUT;
        end else if (status.both_even) begin
          cmd.strip = 1'b1;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (status.gcd_done) begin
          state_next = S_DIVI;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          kind_next  = KIND_DIV;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.res_wr = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rar_datapath.sv
// Datapath of the rational arithmetic reduce unit: multiplier, combiner,
// binary GCD, two-lane restoring divider and output register. Uses rar_pkg.
`default_nettype none

module rar_datapath #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rar_pkg::cmd_t              cmd,
  output rar_pkg::status_t                status,
  input  wire logic [1:0]                 mode,
  input  wire logic [OPERAND_WIDTH-1:0]   a_numer,
  input  wire logic [OPERAND_WIDTH-1:0]   a_denom,
  input  wire logic [OPERAND_WIDTH-1:0]   b_numer,
  input  wire logic [OPERAND_WIDTH-1:0]   b_denom,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [rar_pkg::NUMER_W-1:0]     res_numer,
  output logic [rar_pkg::DENOM_W-1:0]     res_denom,
  output logic                            res_err
);
  import rar_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int NW = 2 * W;
  localparam int KW = $clog2(NW + 1);
  localparam int XW = (NW + 1 > NUMER_W) ? NW + 1 : NUMER_W;

  // Operand magnitudes and signs, held for the whole item.
  logic [1:0]   mode_q;
  logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic         an_neg, ad_neg, bn_neg, bd_neg;

  logic [W-1:0]  mul_a, mul_b;
  logic [NW-1:0] prod, t1, t2;
  logic          t1_neg, t2_neg, den_neg;
  logic [NW-1:0] comb_mag;
  logic          comb_neg;

  logic [NW-1:0] num_mag, den_mag;
  logic          res_neg;
  logic [NW-1:0] u, v, u_next, v_next;
  logic [KW-1:0] k;

  logic [NW-1:0] dvsr;
  logic [NW-1:0] rem [2];
  logic [NW-1:0] quo [2];
  logic [NW-1:0] rem_next [2];
  logic [NW-1:0] quo_next [2];
  logic [NW:0]   rem_sh [2];

  logic [XW-1:0] numer_ext, numer_sgn, denom_ext;

  function automatic logic [W-1:0] magnitude(input logic [W-1:0] x);
    return x[W-1] ? ((~x) + W'(1)) : x;
  endfunction

  // Zero denominators and division by a zero fraction are flagged at accept.
  always_comb begin
    status.in_err    = (a_denom == '0) || (b_denom == '0) ||
                       ((mode == MODE_DIV) && (b_numer == '0));
    status.u_zero    = (u == '0);
    status.both_even = !u[0] && !v[0];
    status.gcd_done  = u[0] && (v == '0);
    status.out_free  = !m_tvalid || m_tready;
  end

  // Multiplier operand selection per mode.
  always_comb begin
    case (cmd.mul_sel)
      MUL_T1: begin
        mul_a = an_mag;
        mul_b = (mode_q == MODE_MUL) ? bn_mag : bd_mag;
      end
      MUL_T2: begin
        mul_a = bn_mag;
        mul_b = ad_mag;
      end
      default: begin
        mul_a = ad_mag;
        mul_b = (mode_q == MODE_DIV) ? bn_mag : bd_mag;
      end
    endcase
  end

  // Signs of the cross products; subtract flips the sign of b.
  always_comb begin
    t1_neg  = an_neg ^ ((mode_q == MODE_MUL) ? bn_neg : bd_neg);
    t2_neg  = bn_neg ^ ad_neg ^ (mode_q == MODE_SUB);
    den_neg = ad_neg ^ ((mode_q == MODE_DIV) ? bn_neg : bd_neg);
    if ((mode_q == MODE_ADD) || (mode_q == MODE_SUB)) begin
      if (t1_neg == t2_neg) begin
        comb_mag = t1 + t2;
        comb_neg = t1_neg;
      end else if (t1 >= t2) begin
        comb_mag = t1 - t2;
        comb_neg = t1_neg;
      end else begin
        comb_mag = t2 - t1;
        comb_neg = t2_neg;
      end
    end else begin
      comb_mag = t1;
      comb_neg = t1_neg;
    end
  end

  // One binary GCD step: drop a factor of two or subtract the smaller.
  always_comb begin
    u_next = u;
    v_next = v;
    if (!u[0]) begin
      u_next = u >> 1;
    end else if (!v[0]) begin
      v_next = v >> 1;
    end else if (u > v) begin
      u_next = u - v;
    end else begin
      v_next = v - u;
    end
  end

  // Restoring division, one quotient bit per lane per cycle.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_sh[i] = {rem[i], quo[i][NW-1]};
      if (rem_sh[i] >= {1'b0, dvsr}) begin
        rem_next[i] = NW'(rem_sh[i] - {1'b0, dvsr});
        quo_next[i] = {quo[i][NW-2:0], 1'b1};
      end else begin
        rem_next[i] = rem_sh[i][NW-1:0];
        quo_next[i] = {quo[i][NW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    numer_ext = {{(XW - NW){1'b0}}, quo[0]};
    denom_ext = {{(XW - NW){1'b0}}, quo[1]};
    numer_sgn = res_neg ? ((~numer_ext) + XW'(1)) : numer_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_wr) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      an_mag <= magnitude(a_numer);
      ad_mag <= magnitude(a_denom);
      bn_mag <= magnitude(b_numer);
      bd_mag <= magnitude(b_denom);
      an_neg <= a_numer[W-1];
      ad_neg <= a_denom[W-1];
      bn_neg <= b_numer[W-1];
      bd_neg <= b_denom[W-1];
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
      if (cmd.mul_sel == MUL_T2) begin
        t1 <= prod;
      end
      if (cmd.mul_sel == MUL_DEN) begin
        t2 <= prod;
      end
    end
    if (cmd.comb) begin
      num_mag <= comb_mag;
      den_mag <= prod;
      res_neg <= comb_neg ^ den_neg;
      u       <= comb_mag;
      v       <= prod;
      k       <= '0;
    end
    if (cmd.strip) begin
      u <= u >> 1;
      v <= v >> 1;
      k <= k + 1'b1;
    end
    if (cmd.gcd_step) begin
      u <= u_next;
      v <= v_next;
    end
    if (cmd.div_init) begin
      dvsr   <= u << k;
      rem[0] <= '0;
      rem[1] <= '0;
      quo[0] <= num_mag;
      quo[1] <= den_mag;
    end
    if (cmd.div_step) begin
      rem[0] <= rem_next[0];
      rem[1] <= rem_next[1];
      quo[0] <= quo_next[0];
      quo[1] <= quo_next[1];
    end
    if (cmd.res_wr) begin
      case (cmd.res_kind)
        KIND_ERR: begin
          res_numer <= '0;
          res_denom <= '0;
          res_err   <= 1'b1;
        end
        KIND_ZERO: begin
          res_numer <= '0;
          res_denom <= DENOM_W'(1);
          res_err   <= 1'b0;
        end
        default: begin
          res_numer <= numer_sgn[NUMER_W-1:0];
          res_denom <= denom_ext[DENOM_W-1:0];
          res_err   <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The GCD divides both values, so both divisions must come out exact.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.res_wr && (cmd.res_kind == KIND_DIV)) |-> (rem[0] == '0 && rem[1] == '0))
    else $error("rar_datapath: inexact reduction");

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (dvsr != '0))
    else $error("rar_datapath: zero divisor in divider");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res_err) |-> (res_denom != '0))
    else $error("rar_datapath: zero denominator without error flag");
`endif

endmodule

`default_nettype wire

>>> rtl/rational_arith_reduce_unit.sv
// Top level of the rational arithmetic reduce unit: stream ports, field
// packing, controller and datapath. Uses rar_pkg, rar_ctrl and rar_datapath.
`default_nettype none

// Adds, subtracts, multiplies or divides two signed fractions and returns the
// result in lowest terms with a positive denominator; a zero result comes back
// as 0/1, and a zero input denominator or a divide by a zero fraction comes
// back as 0/0 with the error flag set on m_tuser. One word is worked at a
// time: s_tready is high only while the unit is idle, and the finished word
// sits in an output register, so the next input word is taken while the
// previous result still waits on m_tready. The time to a result grows with
// the count of common factors of two in the unreduced numerator and
// denominator, which are stripped one at a time, and with the number of
// binary GCD steps, done by a one-step-per-cycle GCD subtractor; the
// bit-per-cycle divider then scales numerator and denominator in two
// parallel lanes. For every kind of result, error and zero ones included,
// the next input word can be taken from the cycle in which the result word
// becomes valid. A finished word that finds the previous result still
// unaccepted holds until m_tready frees the output register, and no input
// word is taken during that wait.
module rational_arith_reduce_unit #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // a_numer, a_denom, b_numer, b_denom (OPERAND_WIDTH each), zero padded
  input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   s_tdata,
  // mode
  input  wire logic [1:0]                             s_tuser,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // res_numer [32:0], res_denom [63:33]
  output logic [rar_pkg::NUMER_W+rar_pkg::DENOM_W-1:0] m_tdata,
  // zero_div_error
  output logic                                        m_tuser
);
  import rar_pkg::*;

  localparam int W = OPERAND_WIDTH;

  cmd_t    cmd;
  status_t status;

  logic [NUMER_W-1:0] res_numer;
  logic [DENOM_W-1:0] res_denom;
  logic               res_err;

  rar_ctrl #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Unpack the input word: first field in the lowest bits.
  rar_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .mode      (s_tuser),
    .a_numer   (s_tdata[W-1:0]),
    .a_denom   (s_tdata[2*W-1:W]),
    .b_numer   (s_tdata[3*W-1:2*W]),
    .b_denom   (s_tdata[4*W-1:3*W]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .res_numer (res_numer),
    .res_denom (res_denom),
    .res_err   (res_err)
  );

  // Pack the result word: numerator low, denominator above it.
  assign m_tdata = {res_denom, res_numer};
  assign m_tuser = res_err;

endmodule

`default_nettype wire
